[rtl/asfc_pkg.sv]
// Shared types, widths and constants for the audio sample filter chain.
package asfc_pkg;

   localparam int SAMPLE_W           = 16;
   localparam int FRAC_W             = 15;
   localparam int COEF_W             = 16;
   localparam int THRESH_W           = 15;
   localparam int WSIZE_W            = 5;
   localparam int HP_W               = 40;
   localparam int MCAND_W            = HP_W + 1;
   localparam int PROD_W             = MCAND_W + COEF_W;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 16;
   localparam int MAX_WINDOW_DEFAULT = 16;

   // Register reset values
   localparam logic [COEF_W-1:0]   ALPHA_RESET  = 16'd0;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd27852;
   localparam logic [COEF_W-1:0]   FACTOR_RESET = 16'd29491;
   localparam logic [WSIZE_W-1:0]  WSIZE_RESET  = 5'd5;

   // Saturation bounds
   localparam logic [HP_W-1:0]     HP_MAX     = {1'b0, {(HP_W-1){1'b1}}};
   localparam logic [HP_W-1:0]     HP_MIN     = {1'b1, {(HP_W-1){1'b0}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Window bookkeeping widths
   function automatic int fill_w(input int max_window);
      return $clog2(max_window + 1);
   endfunction

   function automatic int sum_w(input int max_window);
      return SAMPLE_W + $clog2(max_window + 1);
   endfunction

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILTER_ENABLE,
      CSR_HIGHPASS_ENABLE,
      CSR_CLIP_ENABLE,
      CSR_SMOOTH_ENABLE,
      CSR_HIGHPASS_ALPHA,
      CSR_CLIP_THRESHOLD,
      CSR_CLIP_FACTOR,
      CSR_WINDOW_SIZE
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HP_START,
      ST_HP_MUL,
      ST_HP_FIX,
      ST_HP_OUT,
      ST_CLIP_CHECK,
      ST_CLIP_MUL,
      ST_CLIP_FIX,
      ST_SM_FETCH,
      ST_SM_PUSH,
      ST_SM_DIV_START,
      ST_SM_DIV,
      ST_SM_FIX,
      ST_DONE
   } state_type;

   // Commands to the moving-average window
   typedef struct packed {
      logic clear;
      logic fetch;
      logic push;
   } win_cmd_type;

endpackage

[rtl/audio_sample_filter_chain.sv]
// Top level: register file, stage sequencer, high-pass and clip datapath, response register.
//
// Usage. Samples arrive on the req_ channel (req_sample_in, req_new_call) and one
// filtered sample leaves per request on the rsp_ channel (rsp_sample_out); both use
// valid/ready. Registers are written through the csr_ channel (csr_index, csr_data),
// which is always ready; write them only while no request is in flight.
// req_new_call clears the high-pass history and the averaging window before
// that sample is processed, even with the filter switched off.
// With the filter off or all stages off a request goes straight to the done state;
// the clip stage scales a sample only when its magnitude exceeds the threshold.
// The high-pass and the clip share one bit-serial coefficient multiplier, and the
// average uses a divider that yields one quotient bit per cycle.
// One request is processed at a time; the next is accepted in the idle state that
// follows the move of the previous result into the response register.
// A stalled receiver holds the result in the response register; a following
// request is still taken and worked on, then waits until that register frees up.
// Reset restores the register defaults and clears all filter history; the window
// store itself is not cleared, only entries inside the fill are ever used.
module audio_sample_filter_chain #(
   parameter int MAX_WINDOW = asfc_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [asfc_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  logic                                   req_new_call,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [asfc_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [asfc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [asfc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import asfc_pkg::*;

   localparam int FILL_W = fill_w(MAX_WINDOW);
   localparam int SUM_W  = sum_w(MAX_WINDOW);
   localparam int QUO_W  = PROD_W - FRAC_W;
   localparam int HPQ_W  = HP_W - FRAC_W;
   localparam int PAD_W  = MCAND_W - SAMPLE_W - 1 - FRAC_W;

   // Configuration registers
   logic                 filt_en_ff;
   logic                 hp_en_ff;
   logic                 clip_en_ff;
   logic                 smooth_en_ff;
   logic [COEF_W-1:0]    alpha_ff;
   logic [THRESH_W-1:0]  thresh_ff;
   logic [COEF_W-1:0]    factor_ff;
   logic [WSIZE_W-1:0]   wsize_ff;

   // Sequencer and datapath state
   state_type                  state_ff, state_in;
   state_type                  first_state, after_clip, after_hp;
   logic signed [HP_W-1:0]     hp_ff;
   logic signed [SAMPLE_W-1:0] prev_ff;
   logic signed [SAMPLE_W-1:0] smp_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                       rsp_valid_ff;

   logic req_fire;
   logic rsp_fire;
   logic load_rsp;

   // Multiplier, divider, window
   logic                      mul_start;
   logic signed [MCAND_W-1:0] mul_mcand;
   logic        [COEF_W-1:0]  mul_mplr;
   logic                      mul_done;
   logic signed [PROD_W-1:0]  mul_product;
   logic                      div_start;
   logic                      div_done;
   logic signed [SUM_W-1:0]   div_quotient;
   win_cmd_type               win_cmd;
   logic signed [SUM_W-1:0]   win_sum;
   logic        [FILL_W-1:0]  win_fill;

   // Arithmetic around the multiplier
   logic        [SAMPLE_W:0]   hp_diff;
   logic signed [MCAND_W-1:0]  hp_d;
   logic                       prod_round;
   logic signed [QUO_W-1:0]    prod_q;
   logic        [HP_W-1:0]     prod_sat_hp;
   logic        [SAMPLE_W-1:0] prod_sat_smp;
   logic                       hp_round;
   logic signed [HPQ_W-1:0]    hp_q;
   logic        [SAMPLE_W-1:0] hp_sat_smp;
   logic        [SAMPLE_W:0]   clip_mag;
   logic                       clip_over;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         filt_en_ff   <= 1'b1;
         hp_en_ff     <= 1'b0;
         clip_en_ff   <= 1'b1;
         smooth_en_ff <= 1'b0;
         alpha_ff     <= ALPHA_RESET;
         thresh_ff    <= THRESH_RESET;
         factor_ff    <= FACTOR_RESET;
         wsize_ff     <= WSIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FILTER_ENABLE:   filt_en_ff   <= csr_data[0];
            CSR_HIGHPASS_ENABLE: hp_en_ff     <= csr_data[0];
            CSR_CLIP_ENABLE:     clip_en_ff   <= csr_data[0];
            CSR_SMOOTH_ENABLE:   smooth_en_ff <= csr_data[0];
            CSR_HIGHPASS_ALPHA:  alpha_ff     <= csr_data[COEF_W-1:0];
            CSR_CLIP_THRESHOLD:  thresh_ff    <= csr_data[THRESH_W-1:0];
            CSR_CLIP_FACTOR:     factor_ff    <= csr_data[COEF_W-1:0];
            CSR_WINDOW_SIZE:     wsize_ff     <= csr_data[WSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // High-pass operand: y_prev + (x - x_prev) * 2^15
   always_comb begin
      hp_diff = {smp_ff[SAMPLE_W-1], smp_ff} - {prev_ff[SAMPLE_W-1], prev_ff};
      hp_d    = {hp_ff[HP_W-1], hp_ff}
              + {{PAD_W{hp_diff[SAMPLE_W]}}, hp_diff, {FRAC_W{1'b0}}};
   end

   // Product / 2^15 toward zero, then saturation to the high-pass and sample ranges
   always_comb begin
      prod_round = mul_product[PROD_W-1] && (|mul_product[FRAC_W-1:0]);
      prod_q     = mul_product[PROD_W-1:FRAC_W] + QUO_W'(prod_round);
      if ((&prod_q[QUO_W-1:HP_W-1]) || !(|prod_q[QUO_W-1:HP_W-1])) begin
         prod_sat_hp = prod_q[HP_W-1:0];
      end else begin
         prod_sat_hp = prod_q[QUO_W-1] ? HP_MIN : HP_MAX;
      end
      if ((&prod_q[QUO_W-1:SAMPLE_W-1]) || !(|prod_q[QUO_W-1:SAMPLE_W-1])) begin
         prod_sat_smp = prod_q[SAMPLE_W-1:0];
      end else begin
         prod_sat_smp = prod_q[QUO_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end
   end

   // High-pass stage output: state / 2^15 toward zero, saturated
   always_comb begin
      hp_round = hp_ff[HP_W-1] && (|hp_ff[FRAC_W-1:0]);
      hp_q     = hp_ff[HP_W-1:FRAC_W] + HPQ_W'(hp_round);
      if ((&hp_q[HPQ_W-1:SAMPLE_W-1]) || !(|hp_q[HPQ_W-1:SAMPLE_W-1])) begin
         hp_sat_smp = hp_q[SAMPLE_W-1:0];
      end else begin
         hp_sat_smp = hp_q[HPQ_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end
   end

   // Spike detect
   always_comb begin
      clip_mag  = smp_ff[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {smp_ff[SAMPLE_W-1], smp_ff})
                                     : {1'b0, smp_ff};
      clip_over = clip_mag > {2'b00, thresh_ff};
   end

   // Stage routing from the enables
   always_comb begin
      after_clip = smooth_en_ff ? ST_SM_FETCH : ST_DONE;
      after_hp   = clip_en_ff ? ST_CLIP_CHECK : after_clip;
      if (!filt_en_ff) begin
         first_state = ST_DONE;
      end else if (hp_en_ff) begin
         first_state = ST_HP_START;
      end else begin
         first_state = after_hp;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:         if (req_fire) state_in = first_state;
         ST_HP_START:     state_in = ST_HP_MUL;
         ST_HP_MUL:       if (mul_done) state_in = ST_HP_FIX;
         ST_HP_FIX:       state_in = ST_HP_OUT;
         ST_HP_OUT:       state_in = after_hp;
         ST_CLIP_CHECK:   state_in = clip_over ? ST_CLIP_MUL : after_clip;
         ST_CLIP_MUL:     if (mul_done) state_in = ST_CLIP_FIX;
         ST_CLIP_FIX:     state_in = after_clip;
         ST_SM_FETCH:     state_in = ST_SM_PUSH;
         ST_SM_PUSH:      state_in = ST_SM_DIV_START;
         ST_SM_DIV_START: state_in = ST_SM_DIV;
         ST_SM_DIV:       if (div_done) state_in = ST_SM_FIX;
         ST_SM_FIX:       state_in = ST_DONE;
         ST_DONE:         if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:         state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready     = 1'b0;
      mul_start     = 1'b0;
      mul_mcand     = {{(MCAND_W-SAMPLE_W){smp_ff[SAMPLE_W-1]}}, smp_ff};
      mul_mplr      = factor_ff;
      div_start     = 1'b0;
      win_cmd       = '0;
      load_rsp      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            win_cmd.clear = req_valid && req_new_call;
         end
         ST_HP_START: begin
            mul_start = 1'b1;
            mul_mcand = hp_d;
            mul_mplr  = alpha_ff;
         end
         ST_CLIP_CHECK:   mul_start     = clip_over;
         ST_SM_FETCH:     win_cmd.fetch = 1'b1;
         ST_SM_PUSH:      win_cmd.push  = 1'b1;
         ST_SM_DIV_START: div_start     = 1'b1;
         ST_DONE:         load_rsp      = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // High-pass history
   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff   <= '0;
         prev_ff <= '0;
      end else if (state_ff == ST_IDLE && req_fire && req_new_call) begin
         hp_ff   <= '0;
         prev_ff <= '0;
      end else if (state_ff == ST_HP_FIX) begin
         hp_ff   <= prod_sat_hp;
         prev_ff <= smp_ff;
      end
   end

   // Working sample, rewritten by each stage
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE:     if (req_fire) smp_ff <= req_sample_in;
         ST_HP_OUT:   smp_ff <= hp_sat_smp;
         ST_CLIP_FIX: smp_ff <= prod_sat_smp;
         ST_SM_FIX:   smp_ff <= div_quotient[SAMPLE_W-1:0];
         default: ;
      endcase
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_sample_ff <= smp_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   asfc_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplr    (mul_mplr),
      .done    (mul_done),
      .product (mul_product)
   );

   asfc_window #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .cmd     (win_cmd),
      .win_len (wsize_ff),
      .sample  (smp_ff),
      .sum     (win_sum),
      .fill    (win_fill)
   );

   asfc_serial_div #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (win_sum),
      .divisor  (win_fill),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Multiplier completes only while the sequencer waits for it
   a_mul_done_waited: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_HP_MUL || state_ff == ST_CLIP_MUL))
      else $error("multiplier finished outside a wait state");

   // Divider completes only while the sequencer waits for it
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_SM_DIV))
      else $error("divider finished outside its wait state");

   // Window never holds more samples than the store
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      win_fill <= FILL_W'(MAX_WINDOW))
      else $error("window fill beyond store depth");

   // One request in work at a time
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted while another is in work");

   // A finished result waits while the response register is stalled
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE))
      else $error("result left the sequencer while the response register was full");

endmodule

[rtl/asfc_serial_mul.sv]
// Shift-add multiplier, signed multiplicand by unsigned coefficient, one coefficient bit per cycle.
module asfc_serial_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [asfc_pkg::MCAND_W-1:0] mcand,
   input  logic        [asfc_pkg::COEF_W-1:0]  mplr,
   output logic                                done,
   output logic signed [asfc_pkg::PROD_W-1:0]  product
);
   import asfc_pkg::*;

   localparam int CNT_W = $clog2(COEF_W + 1);

   logic signed [MCAND_W:0]   hi_ff, hi_in;
   logic        [COEF_W-1:0]  lo_ff, lo_in;
   logic signed [MCAND_W-1:0] m_ff, m_in;
   logic        [CNT_W-1:0]   cnt_ff, cnt_in;
   logic                      run_ff, run_in;
   logic                      done_ff, done_in;
   logic        [MCAND_W:0]   acc;

   // One step: add multiplicand if the current coefficient bit is set, shift right
   always_comb begin
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      m_in    = m_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      acc     = hi_ff + (lo_ff[0] ? {m_ff[MCAND_W-1], m_ff} : {(MCAND_W+1){1'b0}});
      if (start) begin
         hi_in  = '0;
         lo_in  = mplr;
         m_in   = mcand;
         cnt_in = CNT_W'(COEF_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         hi_in  = {acc[MCAND_W], acc[MCAND_W:1]};
         lo_in  = {acc[0], lo_ff[COEF_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Operand and partial product shift registers
   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      m_ff  <= m_in;
   end

   assign done    = done_ff;
   assign product = $signed({hi_ff[MCAND_W-1:0], lo_ff});

endmodule

[rtl/asfc_serial_div.sv]
// Restoring divider for the window sum by the fill count, one quotient bit per cycle.
module asfc_serial_div #(
   parameter int MAX_WINDOW = asfc_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   input  logic signed [asfc_pkg::sum_w(MAX_WINDOW)-1:0]  dividend,
   input  logic        [asfc_pkg::fill_w(MAX_WINDOW)-1:0] divisor,
   output logic                                           done,
   output logic signed [asfc_pkg::sum_w(MAX_WINDOW)-1:0]  quotient
);
   import asfc_pkg::*;

   localparam int DVD_W = sum_w(MAX_WINDOW);
   localparam int DVS_W = fill_w(MAX_WINDOW);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   trial_sub;
   logic             fits;
   logic [DVD_W-1:0] quo_neg;

   // Magnitude division, dividend shifts out MSB first as quotient bits shift in
   always_comb begin
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      trial     = {rem_ff, quo_ff[DVD_W-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      fits      = trial >= {1'b0, dvs_ff};
      if (start) begin
         neg_in = dividend[DVD_W-1];
         quo_in = dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(DVD_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // Truncation toward zero: negate the magnitude quotient for a negative sum
   assign quo_neg  = ~quo_ff + 1'b1;
   assign quotient = neg_ff ? quo_neg : quo_ff;
   assign done     = done_ff;

endmodule

[rtl/asfc_window.sv]
// Moving-average window: sample store, write pointer, fill count and running sum.
module asfc_window #(
   parameter int MAX_WINDOW = asfc_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  asfc_pkg::win_cmd_type                          cmd,
   input  logic        [asfc_pkg::WSIZE_W-1:0]            win_len,
   input  logic signed [asfc_pkg::SAMPLE_W-1:0]           sample,
   output logic signed [asfc_pkg::sum_w(MAX_WINDOW)-1:0]  sum,
   output logic        [asfc_pkg::fill_w(MAX_WINDOW)-1:0] fill
);
   import asfc_pkg::*;

   localparam int FILL_W = fill_w(MAX_WINDOW);
   localparam int SUM_W  = sum_w(MAX_WINDOW);
   localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CMP_W  = ((FILL_W > WSIZE_W) ? FILL_W : WSIZE_W) + 1;
   localparam int ADR_W  = FILL_W + 1;

   localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_WINDOW);
   localparam logic [ADR_W-1:0] MAX_ADR  = ADR_W'(MAX_WINDOW);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_WINDOW - 1);

   logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic        [FILL_W-1:0]   fill_ff, fill_in;
   logic        [IDX_W-1:0]    ptr_ff, ptr_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic        [CMP_W-1:0]    size_ext;
   logic        [CMP_W-1:0]    w_eff;
   logic                       evict;
   logic        [ADR_W-1:0]    old_raw;
   logic        [ADR_W-1:0]    old_wrap;
   logic        [IDX_W-1:0]    old_idx;

   // Effective window length and the slot of the oldest held sample
   always_comb begin
      size_ext = CMP_W'(win_len);
      if (size_ext == '0) begin
         w_eff = CMP_W'(1);
      end else if (size_ext > MAX_CMP) begin
         w_eff = MAX_CMP;
      end else begin
         w_eff = size_ext;
      end
      evict    = CMP_W'(fill_ff) >= w_eff;
      old_raw  = ADR_W'(ptr_ff) + MAX_ADR - ADR_W'(fill_ff);
      old_wrap = (old_raw >= MAX_ADR) ? (old_raw - MAX_ADR) : old_raw;
      old_idx  = old_wrap[IDX_W-1:0];
   end

   // Bookkeeping update on clear or push
   always_comb begin
      fill_in = fill_ff;
      ptr_in  = ptr_ff;
      sum_in  = sum_ff;
      if (cmd.clear) begin
         fill_in = '0;
         ptr_in  = '0;
         sum_in  = '0;
      end else if (cmd.push) begin
         sum_in  = sum_ff + SUM_W'(sample) - (evict ? SUM_W'(rd_ff) : {SUM_W{1'b0}});
         fill_in = evict ? fill_ff : (fill_ff + 1'b1);
         ptr_in  = (ptr_ff == LAST_IDX) ? '0 : (ptr_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         ptr_ff  <= '0;
         sum_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         ptr_ff  <= ptr_in;
         sum_ff  <= sum_in;
      end
   end

   // Sample store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[ptr_ff] <= sample;
      end
      if (cmd.fetch) begin
         rd_ff <= mem[old_idx];
      end
   end

   assign sum  = sum_ff;
   assign fill = fill_ff;

endmodule
